### hdl/rab_pkg.sv
// Shared types, constants and helpers for the row activity bounds unit.
package rab_pkg;

    localparam int ACC_W   = 48;
    localparam int CNT_W   = 11;
    localparam int EPOCH_W = 8;

    localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic              new_problem;
        logic [7:0]        row;
        logic signed [31:0] coefficient;
        logic signed [31:0] var_lower;
        logic signed [31:0] var_upper;
        logic              lower_finite;
        logic              upper_finite;
    } rab_in_t;

    typedef struct packed {
        logic [7:0]              out_row;
        logic signed [ACC_W-1:0] min_activity;
        logic signed [ACC_W-1:0] max_activity;
        logic                    min_is_neg_inf;
        logic                    max_is_pos_inf;
        logic [CNT_W-1:0]        nonzero_count;
        logic                    saturated;
    } rab_out_t;

    // One row entry as kept in the row memory. The tag holds the epoch in
    // which the row was last written; tag zero never matches a live epoch.
    typedef struct packed {
        logic [EPOCH_W-1:0]      tag;
        logic signed [ACC_W-1:0] min_acc;
        logic signed [ACC_W-1:0] max_acc;
        logic                    min_inf;
        logic                    max_inf;
        logic [CNT_W-1:0]        count;
        logic                    sat;
    } rab_entry_t;

    // Saturating add; the top bit of the result flags a clamp.
    function automatic logic [ACC_W:0] sat_add(logic signed [ACC_W-1:0] acc,
                                               logic signed [ACC_W-1:0] term);
        logic signed [ACC_W:0] sum;
        logic [ACC_W:0]        res;
        sum = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            res = sum[ACC_W] ? {1'b1, ACC_MIN} : {1'b1, ACC_MAX};
        end else begin
            res = {1'b0, sum[ACC_W-1:0]};
        end
        return res;
    endfunction

endpackage

### hdl/rab_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/rab_prod.sv
// Registered coefficient-times-bound products, scaled to Q32.16 with floor.
module rab_prod (
    input  logic                              clk,
    input  logic signed [31:0]                coefficient,
    input  logic signed [31:0]                var_lower,
    input  logic signed [31:0]                var_upper,
    output logic signed [rab_pkg::ACC_W-1:0]  min_term,
    output logic signed [rab_pkg::ACC_W-1:0]  max_term
);
    import rab_pkg::*;

    logic               pos;
    logic signed [31:0] min_b;
    logic signed [31:0] max_b;
    logic signed [63:0] min_p;
    logic signed [63:0] max_p;
    logic signed [ACC_W-1:0] min_term_reg;
    logic signed [ACC_W-1:0] max_term_reg;

    // A negative coefficient swaps which bound drives each extreme.
    assign pos   = coefficient > 32'sd0;
    assign min_b = pos ? var_lower : var_upper;
    assign max_b = pos ? var_upper : var_lower;
    assign min_p = coefficient * min_b;
    assign max_p = coefficient * max_b;

    // Dropping the low 16 bits of the two's complement product rounds
    // toward minus infinity.
    always_ff @(posedge clk)
    begin
        min_term_reg <= min_p[63:16];
        max_term_reg <= max_p[63:16];
    end

    assign min_term = min_term_reg;
    assign max_term = max_term_reg;

endmodule

### hdl/row_activity_bounds_unit.sv
// Top level of the row activity bounds unit: control, row update and output stage.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------
//  req     | in        | req_valid / req_ready     | rab_in_t  (one nonzero)
//  rsp     | out       | rsp_valid / rsp_ready     | rab_out_t (row values)
//
// Each item passes through accept, row memory read, then update and write
// back; the registered read of the row memory ahead of the update sets this order.
// After reset a sweep over all ROWS entries tags every row entry invalid before the
// first item is taken. Rows are cleared by advancing an epoch; when the epoch
// wraps, the item carrying new_problem waits for another sweep over all entries.
// A result held on rsp stalls only the update cycle of the following item.
module row_activity_bounds_unit #(
    parameter int ROWS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rab_pkg::rab_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rab_pkg::rab_out_t rsp
);
    import rab_pkg::*;

    localparam int IDX_W = $clog2(ROWS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ROWS - 1);
    localparam int ENTRY_W = $bits(rab_entry_t);
    localparam int unsigned ROW_RECIP = (65536 + ROWS - 1) / ROWS;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPD
    } state_t;

    state_t             state_reg, state_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic               held_reg, held_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rab_in_t            item_reg, item_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    rab_out_t           rsp_reg, rsp_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    rab_entry_t         wr_data;
    logic               rd_en;
    logic [ENTRY_W-1:0] rd_raw;
    rab_entry_t         rd_entry;

    logic [31:0]        row_quot;
    logic [IDX_W-1:0]   row_idx;

    logic signed [ACC_W-1:0] min_term;
    logic signed [ACC_W-1:0] max_term;

    logic               seen;
    logic               nonzero;
    logic               pos;
    logic               min_fin;
    logic               max_fin;
    logic [ACC_W:0]     min_sum;
    logic [ACC_W:0]     max_sum;
    rab_entry_t         upd;
    rab_out_t           result;

    // Row index modulo ROWS by reciprocal multiplication; the 16-bit
    // reciprocal is exact for every 8-bit row.
    always_comb
    begin
        row_quot = (32'(req.row) * 32'(ROW_RECIP)) >> 16;
        row_idx  = IDX_W'(32'(req.row) - row_quot * 32'(ROWS));
    end

    rab_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(ROWS)
    ) u_row_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(idx_reg),
        .rd_data(rd_raw)
    );

    assign rd_entry = rd_raw;

    rab_prod u_prod (
        .clk        (clk),
        .coefficient(item_reg.coefficient),
        .var_lower  (item_reg.var_lower),
        .var_upper  (item_reg.var_upper),
        .min_term   (min_term),
        .max_term   (max_term)
    );

    // Row update from the entry just read and the registered products.
    always_comb
    begin
        seen    = rd_entry.tag == epoch_reg;
        nonzero = item_reg.coefficient != 32'sd0;
        pos     = item_reg.coefficient > 32'sd0;
        min_fin = pos ? item_reg.lower_finite : item_reg.upper_finite;
        max_fin = pos ? item_reg.upper_finite : item_reg.lower_finite;

        upd = seen ? rd_entry : '0;
        min_sum = sat_add(upd.min_acc, min_term);
        max_sum = sat_add(upd.max_acc, max_term);

        if (nonzero)
        begin
            upd.tag = epoch_reg;
            if (upd.count != CNT_MAX)
            begin
                upd.count = upd.count + CNT_W'(1);
            end
            if (!min_fin)
            begin
                upd.min_inf = 1'b1;
            end
            else if (!upd.min_inf)
            begin
                upd.min_acc = min_sum[ACC_W-1:0];
                upd.sat     = upd.sat | min_sum[ACC_W];
            end
            if (!max_fin)
            begin
                upd.max_inf = 1'b1;
            end
            else if (!upd.max_inf)
            begin
                upd.max_acc = max_sum[ACC_W-1:0];
                upd.sat     = upd.sat | max_sum[ACC_W];
            end
        end

        result.out_row        = item_reg.row;
        result.min_activity   = upd.min_inf ? '0 : upd.min_acc;
        result.max_activity   = upd.max_inf ? '0 : upd.max_acc;
        result.min_is_neg_inf = upd.min_inf;
        result.max_is_pos_inf = upd.max_inf;
        result.nonzero_count  = upd.count;
        result.saturated      = upd.sat;
    end

    always_comb
    begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        clr_cnt_next   = clr_cnt_reg;
        held_next      = held_reg;
        rsp_valid_next = rsp_valid_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = upd;
        rd_en          = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == IDX_LAST)
                begin
                    clr_cnt_next = '0;
                    state_next   = held_reg ? S_READ : S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    idx_next   = row_idx;
                    held_next  = 1'b1;
                    state_next = S_READ;
                    if (req.new_problem)
                    begin
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            epoch_next = EPOCH_FIRST;
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    wr_en          = nonzero;
                    rsp_valid_next = 1'b1;
                    rsp_next       = result;
                    held_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            epoch_reg     <= EPOCH_FIRST;
            clr_cnt_reg   <= '0;
            held_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            clr_cnt_reg   <= clr_cnt_next;
            held_reg      <= held_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        rsp_reg  <= rsp_next;
    end

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### bench/row_activity_bounds_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for row_activity_bounds_unit: a directed table, then random problems.
module row_activity_bounds_unit_test;
    import rab_pkg::*;

    localparam int NROWS = 256;
    localparam int CLK_PERIOD = 12;
    localparam longint ACT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACT_LO = -64'sh0000_8000_0000_0000;
    localparam longint TWO_POW_46 = 64'sh0000_4000_0000_0000;
    localparam int unsigned COUNT_CAP = 2047;
    localparam int ONE = 32'sh0001_0000;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    rab_in_t  req;
    logic     rsp_valid;
    logic     rsp_ready;
    rab_out_t rsp;

    row_activity_bounds_unit #(.ROWS(NROWS)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Predicted per-row state.
    bit          row_live[NROWS];
    longint      min_sum[NROWS];
    longint      max_sum[NROWS];
    bit          min_unbounded[NROWS];
    bit          max_unbounded[NROWS];
    int unsigned nz_count[NROWS];
    bit          clamped[NROWS];

    typedef struct {
        rab_in_t  stim;
        bit       known;
        rab_out_t want;
    } directed_t;

    rab_out_t  pending_rows[$];
    directed_t directed_tbl[$];

    int errors;
    int items_sent;
    int results_seen;
    int problems_opened;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic longint scale_product(longint c, longint b);
        longint p;
        p = c * b;
        return p >>> 16;
    endfunction

    function automatic void add_clamped(inout longint acc, input longint term, inout bit sat);
        longint s;
        s = acc + term;
        if (s > ACT_HI)
        begin
            s = ACT_HI;
            sat = 1'b1;
        end
        else if (s < ACT_LO)
        begin
            s = ACT_LO;
            sat = 1'b1;
        end
        acc = s;
    endfunction

    // Applies one nonzero to the predicted row state and returns the row's values.
    function automatic rab_out_t predict_activity(rab_in_t it);
        int       idx;
        longint   c;
        longint   min_b;
        longint   max_b;
        bit       min_fin;
        bit       max_fin;
        rab_out_t r;
        idx = it.row;
        c = it.coefficient;
        if (it.new_problem)
            foreach (row_live[i]) row_live[i] = 1'b0;
        if (c != 0)
        begin
            if (!row_live[idx])
            begin
                row_live[idx] = 1'b1;
                min_sum[idx] = 0;
                max_sum[idx] = 0;
                min_unbounded[idx] = 1'b0;
                max_unbounded[idx] = 1'b0;
                nz_count[idx] = 0;
                clamped[idx] = 1'b0;
            end
            if (nz_count[idx] < COUNT_CAP)
                nz_count[idx]++;
            // A negative coefficient swaps which bound drives each side.
            min_fin = (c > 0) ? it.lower_finite : it.upper_finite;
            max_fin = (c > 0) ? it.upper_finite : it.lower_finite;
            min_b = (c > 0) ? longint'(it.var_lower) : longint'(it.var_upper);
            max_b = (c > 0) ? longint'(it.var_upper) : longint'(it.var_lower);
            if (!min_fin)
                min_unbounded[idx] = 1'b1;
            else if (!min_unbounded[idx])
                add_clamped(min_sum[idx], scale_product(c, min_b), clamped[idx]);
            if (!max_fin)
                max_unbounded[idx] = 1'b1;
            else if (!max_unbounded[idx])
                add_clamped(max_sum[idx], scale_product(c, max_b), clamped[idx]);
        end
        r = '0;
        r.out_row = it.row;
        if (row_live[idx])
        begin
            if (!min_unbounded[idx])
                r.min_activity = min_sum[idx][47:0];
            if (!max_unbounded[idx])
                r.max_activity = max_sum[idx][47:0];
            r.min_is_neg_inf = min_unbounded[idx];
            r.max_is_pos_inf = max_unbounded[idx];
            r.nonzero_count = nz_count[idx][10:0];
            r.saturated = clamped[idx];
        end
        return r;
    endfunction

    function automatic rab_in_t mk_in(bit np, logic [7:0] row, logic [31:0] c,
                                      logic [31:0] lo, logic [31:0] hi, bit lf, bit uf);
        rab_in_t it;
        it.new_problem = np;
        it.row = row;
        it.coefficient = c;
        it.var_lower = lo;
        it.var_upper = hi;
        it.lower_finite = lf;
        it.upper_finite = uf;
        return it;
    endfunction

    function automatic rab_out_t mk_out(logic [7:0] row, longint mn, longint mx,
                                        bit mi, bit xi, int cnt, bit sat);
        rab_out_t r;
        r.out_row = row;
        r.min_activity = mn[47:0];
        r.max_activity = mx[47:0];
        r.min_is_neg_inf = mi;
        r.max_is_pos_inf = xi;
        r.nonzero_count = cnt[10:0];
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic rab_in_t make_entry(bit np, logic [7:0] row);
        rab_in_t it;
        it.new_problem = np;
        it.row = row;
        it.coefficient = ($urandom_range(0, 9) == 0) ? 32'h0 : rand_q16();
        it.var_lower = rand_q16();
        it.var_upper = rand_q16();
        it.lower_finite = ($urandom_range(0, 99) < 85);
        it.upper_finite = ($urandom_range(0, 99) < 85);
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] row, logic [63:0] got,
                               logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("row %0d %s: got %h, want %h", row, name, got, want));
    endtask

    task automatic add_directed(rab_in_t stim, bit known, rab_out_t want);
        directed_t d;
        d.stim = stim;
        d.known = known;
        d.want = want;
        directed_tbl.push_back(d);
    endtask

    // Offers one item and returns at the edge where it is taken.
    task automatic send_item(rab_in_t it, bit known, rab_out_t want);
        rab_out_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= it;
        @(negedge clk);
        while (!req_ready) @(negedge clk);
        @(posedge clk);
        predicted = predict_activity(it);
        pending_rows.push_back(known ? want : predicted);
        items_sent++;
        if (it.new_problem)
            problems_opened++;
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
    endtask

    // Mostly short problems on a few rows so sums build up, with some lone noise items.
    task automatic run_problems(int n_items);
        int         sent;
        int         len;
        int         i;
        logic [7:0] row;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(make_entry($urandom_range(0, 1), $urandom_range(0, 255)), 1'b0, '0);
                sent++;
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                begin
                    row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 7);
                    send_item(make_entry(i == 0, row), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rsp_ready <= 1'b0;
                rx_hold <= rx_hold - 1;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(negedge clk)
    begin : rsp_monitor
        rab_out_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (pending_rows.size() == 0)
                report_mismatch($sformatf("row %0d: result with no item outstanding",
                                          rsp.out_row));
            else
            begin
                want = pending_rows.pop_front();
                check_field("out_row", want.out_row, 64'(rsp.out_row), 64'(want.out_row));
                check_field("min_activity", want.out_row, 64'(rsp.min_activity),
                            64'(want.min_activity));
                check_field("max_activity", want.out_row, 64'(rsp.max_activity),
                            64'(want.max_activity));
                check_field("min_is_neg_inf", want.out_row, 64'(rsp.min_is_neg_inf),
                            64'(want.min_is_neg_inf));
                check_field("max_is_pos_inf", want.out_row, 64'(rsp.max_is_pos_inf),
                            64'(want.max_is_pos_inf));
                check_field("nonzero_count", want.out_row, 64'(rsp.nonzero_count),
                            64'(want.nonzero_count));
                check_field("saturated", want.out_row, 64'(rsp.saturated),
                            64'(want.saturated));
                results_seen++;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_rows.size());
        $display("row_activity_bounds_unit regression: fail");
        $finish;
    end

    initial
    begin : main
        int         i;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        problems_opened = 0;
        tx_idle_pct = 12;
        rx_idle_pct = 73;
        rx_hold = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        foreach (row_live[k]) row_live[k] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Unseen row after reset reads as all zero.
        add_directed(mk_in(0, 0, 0, 0, 0, 1, 1), 1, mk_out(0, 0, 0, 0, 0, 0, 0));
        add_directed(mk_in(0, 255, ONE, 2 * ONE, 3 * ONE, 1, 1), 1,
                     mk_out(255, 2 * ONE, 3 * ONE, 0, 0, 1, 0));
        add_directed(mk_in(0, 255, -ONE, 2 * ONE, 3 * ONE, 1, 1), 0, '0);
        // Zero coefficient on a live row leaves it alone.
        add_directed(mk_in(0, 255, 0, ONE, ONE, 1, 1), 0, '0);
        add_directed(mk_in(0, 1, ONE, 0, 4 * ONE, 0, 1), 1, mk_out(1, 0, 4 * ONE, 1, 0, 1, 0));
        add_directed(mk_in(0, 1, ONE, ONE, ONE, 1, 1), 0, '0);
        add_directed(mk_in(0, 2, -ONE, ONE, 0, 1, 0), 1, mk_out(2, 0, -ONE, 1, 0, 1, 0));
        // Products round toward minus infinity.
        add_directed(mk_in(0, 3, -1, 1, 1, 1, 1), 1, mk_out(3, -1, -1, 0, 0, 1, 0));
        add_directed(mk_in(0, 3, 1, -1, -1, 1, 1), 0, '0);
        // Extreme coefficients and bounds drive both sums into saturation.
        for (i = 0; i < 4; i++)
            add_directed(mk_in(0, 4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1), 0, '0);
        add_directed(mk_in(0, 5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1), 1,
                     mk_out(5, TWO_POW_46, TWO_POW_46, 0, 0, 1, 0));
        add_directed(mk_in(0, 5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1), 0, '0);
        add_directed(mk_in(1, 255, 0, ONE, ONE, 1, 1), 1, mk_out(255, 0, 0, 0, 0, 0, 0));
        add_directed(mk_in(1, 4, ONE, -ONE, ONE, 1, 1), 1, mk_out(4, -ONE, ONE, 0, 0, 1, 0));
        add_directed(mk_in(0, 4, ONE, 0, 0, 0, 0), 1, mk_out(4, 0, 0, 1, 1, 2, 0));
        // Once both marks are set the sums no longer move.
        add_directed(mk_in(0, 4, -ONE, 5 * ONE, 5 * ONE, 1, 1), 1, mk_out(4, 0, 0, 1, 1, 3, 0));
        add_directed(mk_in(0, 8'hAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1, 1), 0, '0);
        add_directed(mk_in(0, 8'h55, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1, 1), 0, '0);

        @(posedge clk);
        foreach (directed_tbl[k])
            send_item(directed_tbl[k].stim, directed_tbl[k].known, directed_tbl[k].want);

        run_problems(80);
        // Hold the output off long enough for the block to back up its input.
        rx_hold <= 300;
        run_problems(200);
        wait_for_results();
        @(posedge clk);

        tx_idle_pct = 73;
        rx_idle_pct = 12;
        run_problems(100);
        // A run of fresh problems wraps the row epoch and forces a clearing sweep.
        for (i = 0; i < 270; i++)
            send_item(make_entry(1'b1, $urandom), 1'b0, '0);
        run_problems(100);
        wait_for_results();
        @(posedge clk);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_problems(480);

        wait_for_results();
        repeat (16) @(posedge clk);
        while (pending_rows.size() != 0)
        begin
            void'(pending_rows.pop_front());
            report_mismatch("expected result never arrived");
        end

        $display("covered %0d items (%0d opening a new problem), %0d results checked",
                 items_sent, problems_opened, results_seen);
        $display("including saturation, infinite bounds and epoch wrap; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("row_activity_bounds_unit regression: pass");
        else
            $display("row_activity_bounds_unit regression: fail");
        $finish;
    end

endmodule

### files.f
hdl/rab_pkg.sv
hdl/rab_ram.sv
hdl/rab_prod.sv
hdl/row_activity_bounds_unit.sv
bench/row_activity_bounds_unit_test.sv
